// File: rtl/pfid_pkg.sv
// ----------------------------------------------------------------------------
// pfid_pkg
// Shared types and constants for the priority front insert deque.
// ----------------------------------------------------------------------------
package pfid_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int KEY_W    = 8;
    localparam int PAY_W    = 32;
    localparam int ENTRY_W  = KEY_W + PAY_W;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // threshold after reset
    localparam logic [KEY_W-1:0] THRESHOLD_RESET = 8'd60;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd3;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic capture;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_read;
    } t_dp_status;

endpackage

// File: rtl/priority_front_insert_deque.sv
// ----------------------------------------------------------------------------
// priority_front_insert_deque
// Bounded deque: urgent keys go in at the head, others at the tail, removal
// from the head; one result per item with status and occupancy.
// ----------------------------------------------------------------------------
// results: an insert or error result is valid in the cycle after the item is taken,
//   a removal that returns an entry passes the registered store read, then the result registers
// items: one at a time; the controller holds one item from acceptance until its
//   result is taken, output stalls included, and takes no new item before then
// reset: synchronous; pointers and count clear, threshold returns to 60,
//   the entry store is not cleared
module priority_front_insert_deque (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_op,
    input  logic [pfid_pkg::KEY_W-1:0]     i_entry_key,
    input  logic [pfid_pkg::PAY_W-1:0]     i_entry_payload,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [pfid_pkg::STATUS_W-1:0]  o_status,
    output logic [pfid_pkg::KEY_W-1:0]     o_out_key,
    output logic [pfid_pkg::PAY_W-1:0]     o_out_payload,
    output logic [pfid_pkg::OCC_W-1:0]     o_occupancy,
    input  logic                           i_cfg_we,
    input  logic [pfid_pkg::KEY_W-1:0]     i_cfg_data
);

    pfid_pkg::t_cmd       cmd;
    pfid_pkg::t_dp_status dp_status;

    // sequencer
    pfid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall     (i_stall),
        .i_dp_status (dp_status),
        .o_cmd       (cmd),
        .o_stall     (o_stall),
        .o_valid     (o_valid)
    );

    // pointers, store and result registers
    pfid_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_dp_status     (dp_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_entry_key     (i_entry_key),
        .i_entry_payload (i_entry_payload),
        .o_status        (o_status),
        .o_out_key       (o_out_key),
        .o_out_payload   (o_out_payload),
        .o_occupancy     (o_occupancy)
    );

endmodule

// File: rtl/pfid_ram.sv
// ----------------------------------------------------------------------------
// pfid_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pfid_ctrl.sv
// ----------------------------------------------------------------------------
// pfid_ctrl
// Sequencer: takes one item, waits on the store read for a removal, holds the result.
// ----------------------------------------------------------------------------
module pfid_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_stall,
    input  pfid_pkg::t_dp_status   i_dp_status,
    output pfid_pkg::t_cmd         o_cmd,
    output logic                   o_stall,
    output logic                   o_valid
);

    pfid_pkg::t_state r_state;
    pfid_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfid_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfid_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_dp_status.need_read ? pfid_pkg::ST_READ : pfid_pkg::ST_RESP;
                end
            end
            pfid_pkg::ST_READ: begin
                n_state = pfid_pkg::ST_RESP;
            end
            pfid_pkg::ST_RESP: begin
                if (!i_stall) begin
                    n_state = pfid_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfid_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.accept  = 1'b0;
        o_cmd.capture = 1'b0;
        o_stall       = 1'b1;
        o_valid       = 1'b0;
        case (r_state)
            pfid_pkg::ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            pfid_pkg::ST_READ: begin
                o_cmd.capture = 1'b1;
            end
            pfid_pkg::ST_RESP: begin
                o_valid = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/pfid_dp.sv
// ----------------------------------------------------------------------------
// pfid_dp
// Datapath: head and tail pointers, entry count, threshold, entry store and
// result registers.
// ----------------------------------------------------------------------------
module pfid_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pfid_pkg::t_cmd                 i_cmd,
    output pfid_pkg::t_dp_status           o_dp_status,
    input  logic                           i_cfg_we,
    input  logic [pfid_pkg::KEY_W-1:0]     i_cfg_data,
    input  logic                           i_op,
    input  logic [pfid_pkg::KEY_W-1:0]     i_entry_key,
    input  logic [pfid_pkg::PAY_W-1:0]     i_entry_payload,
    output logic [pfid_pkg::STATUS_W-1:0]  o_status,
    output logic [pfid_pkg::KEY_W-1:0]     o_out_key,
    output logic [pfid_pkg::PAY_W-1:0]     o_out_payload,
    output logic [pfid_pkg::OCC_W-1:0]     o_occupancy
);

    localparam logic [pfid_pkg::IDX_W-1:0] PtrLast =
        pfid_pkg::IDX_W'(pfid_pkg::QUEUE_DEPTH - 1);
    localparam logic [pfid_pkg::CNT_W-1:0] CntFull =
        pfid_pkg::CNT_W'(pfid_pkg::QUEUE_DEPTH);

    logic [pfid_pkg::IDX_W-1:0]    r_head, n_head;
    logic [pfid_pkg::IDX_W-1:0]    r_tail, n_tail;
    logic [pfid_pkg::CNT_W-1:0]    r_count, n_count;
    logic [pfid_pkg::KEY_W-1:0]    r_threshold;
    logic [pfid_pkg::STATUS_W-1:0] r_status, n_status;
    logic [pfid_pkg::KEY_W-1:0]    r_key, n_key;
    logic [pfid_pkg::PAY_W-1:0]    r_payload, n_payload;

    logic                          is_empty;
    logic                          is_full;
    logic                          urgent;
    logic [pfid_pkg::IDX_W-1:0]    head_inc;
    logic [pfid_pkg::IDX_W-1:0]    head_dec;
    logic [pfid_pkg::IDX_W-1:0]    tail_inc;
    logic                          ram_we;
    logic [pfid_pkg::IDX_W-1:0]    ram_waddr;
    logic                          ram_re;
    logic [pfid_pkg::ENTRY_W-1:0]  ram_rdata;

    // pointer arithmetic with wrap at the queue depth
    assign head_inc = (r_head == PtrLast) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? PtrLast : r_head - 1'b1;
    assign tail_inc = (r_tail == PtrLast) ? '0 : r_tail + 1'b1;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= CntFull);
    assign urgent   = (i_entry_key >= r_threshold);

    // store access for the item being taken
    assign ram_we    = i_cmd.accept && (i_op == pfid_pkg::OP_INSERT) && !is_full;
    assign ram_waddr = urgent ? head_dec : r_tail;
    assign ram_re    = i_cmd.accept && (i_op == pfid_pkg::OP_REMOVE) && !is_empty;

    assign o_dp_status.need_read = (i_op == pfid_pkg::OP_REMOVE) && !is_empty;

    pfid_ram #(
        .WIDTH (pfid_pkg::ENTRY_W),
        .DEPTH (pfid_pkg::QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_entry_key, i_entry_payload}),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // queue update and result fields
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_status  = r_status;
        n_key     = r_key;
        n_payload = r_payload;
        if (i_cmd.accept) begin
            n_status  = pfid_pkg::STATUS_OK;
            n_key     = '0;
            n_payload = '0;
            if (i_op == pfid_pkg::OP_INSERT) begin
                if (is_full) begin
                    n_status = pfid_pkg::STATUS_FULL;
                end else begin
                    if (urgent) begin
                        n_head = head_dec;
                    end else begin
                        n_tail = tail_inc;
                    end
                    n_count = r_count + 1'b1;
                end
            end else begin
                if (is_empty) begin
                    n_status = pfid_pkg::STATUS_EMPTY;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
        end else if (i_cmd.capture) begin
            n_key     = ram_rdata[pfid_pkg::ENTRY_W-1:pfid_pkg::PAY_W];
            n_payload = ram_rdata[pfid_pkg::PAY_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_threshold <= pfid_pkg::THRESHOLD_RESET;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_status      = r_status;
    assign o_out_key     = r_key;
    assign o_out_payload = r_payload;
    assign o_occupancy   = pfid_pkg::OCC_W'(r_count);

endmodule

// File: rtl/pfid_checker.sv
// ----------------------------------------------------------------------------
// pfid_checker
// Port level checks for the priority front insert deque, bound to the top.
// ----------------------------------------------------------------------------
module pfid_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic [pfid_pkg::STATUS_W-1:0]  o_status,
    input  logic [pfid_pkg::KEY_W-1:0]     o_out_key,
    input  logic [pfid_pkg::PAY_W-1:0]     o_out_payload,
    input  logic [pfid_pkg::OCC_W-1:0]     o_occupancy
);

    // an accepted item holds off the next one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after an item");

    // the unused status code never shows
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != pfid_pkg::STATUS_BAD))
        else $error("result with undefined status");

    // error results carry no entry
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != pfid_pkg::STATUS_OK))
            |-> ((o_out_key == '0) && (o_out_payload == '0)))
        else $error("error result carries entry data");

    // no result is shown while an item is still being taken
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result is pending");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_out_key)
            && $stable(o_out_payload) && $stable(o_occupancy)))
        else $error("stalled result changed");

endmodule

bind priority_front_insert_deque pfid_checker u_pfid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_out_key     (o_out_key),
    .o_out_payload (o_out_payload),
    .o_occupancy   (o_occupancy)
);
